@@ rtl/spdt_pkg.sv @@
// ----------------------------------------------------------------------------
// spdt_pkg
// Shared types and constants for the symmetric pair degree table.
// ----------------------------------------------------------------------------
package spdt_pkg;

  // Fixed field widths of the channels
  localparam int ID_W     = 16;
  localparam int DEGREE_W = 32;
  localparam int LEVEL_W  = 2;

  typedef logic [ID_W-1:0]     id_t;
  typedef logic [DEGREE_W-1:0] degree_t;
  typedef logic [LEVEL_W-1:0]  level_t;

  // Request kinds
  typedef enum logic {
    REQ_UPDATE = 1'b0,
    REQ_QUERY  = 1'b1
  } req_type_t;

  // Friend levels reported for a pair
  localparam level_t LEVEL_NONE = 2'd0;
  localparam level_t LEVEL_ALLY = 2'd2;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } spdt_state_t;

endpackage

@@ rtl/spdt_if.sv @@
// ----------------------------------------------------------------------------
// spdt_in_if / spdt_out_if
// Valid/ready channels for request and result transactions.
// ----------------------------------------------------------------------------
interface spdt_in_if import spdt_pkg::*; ();
  logic      valid;
  logic      ready;
  req_type_t req_type;
  id_t       first_id;
  id_t       second_id;
  degree_t   degree_in;

  modport source (output valid, output req_type, output first_id, output second_id,
                  output degree_in, input ready);
  modport sink   (input valid, input req_type, input first_id, input second_id,
                  input degree_in, output ready);
endinterface

interface spdt_out_if import spdt_pkg::*; ();
  logic    valid;
  logic    ready;
  logic    pair_found;
  degree_t degree_out;
  logic    is_ally;
  level_t  friend_level;
  logic    insert_dropped;

  modport source (output valid, output pair_found, output degree_out, output is_ally,
                  output friend_level, output insert_dropped, input ready);
  modport sink   (input valid, input pair_found, input degree_out, input is_ally,
                  input friend_level, input insert_dropped, output ready);
endinterface

@@ rtl/spdt_store.sv @@
// ----------------------------------------------------------------------------
// spdt_store
// Entry memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module spdt_store import spdt_pkg::*; #(
  parameter int DEPTH = 64,
  parameter int KEY_W = 16
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [KEY_W-1:0]         rd_first,
  output logic [KEY_W-1:0]         rd_second,
  output degree_t                  rd_degree,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [KEY_W-1:0]         wr_first,
  input  logic [KEY_W-1:0]         wr_second,
  input  degree_t                  wr_degree
);

  logic [KEY_W-1:0] mem_first  [DEPTH];
  logic [KEY_W-1:0] mem_second [DEPTH];
  degree_t          mem_degree [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_first[wr_addr]  <= wr_first;
      mem_second[wr_addr] <= wr_second;
      mem_degree[wr_addr] <= wr_degree;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_first  <= mem_first[rd_addr];
      rd_second <= mem_second[rd_addr];
      rd_degree <= mem_degree[rd_addr];
    end
  end

endmodule

@@ rtl/symmetric_pair_degree_table.sv @@
// ----------------------------------------------------------------------------
// symmetric_pair_degree_table
// Table of unordered ID pairs with a degree each, searched entry by entry.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : request transactions (req_type, first_id, second_id, degree_in).
//            An update overwrites the degree of a matching pair or appends
//            it unless full; a query only reports. Pairs match in either order.
//   out_ch : exactly one result transaction per request (pair_found,
//            degree_out, is_ally, friend_level, insert_dropped), reporting the
//            table contents before the request.
// Search:
//   A request scans the valid entries in order and stops at the first match.
//   One memory read is issued per cycle and a single pair comparator checks
//   the previous read. in_ch.ready is high only while idle, so a new request
//   is accepted only after the previous search has finished.
// Reset:
//   rst_n clears the entry count and control; entry memory is not cleared.
// Stall:
//   A result waits in the output register; a new request can be accepted
//   meanwhile, and its result waits until the previous one is taken.
// ----------------------------------------------------------------------------
module symmetric_pair_degree_table import spdt_pkg::*; #(
  parameter int ENTRIES = 64,
  parameter int ID_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  spdt_in_if.sink   in_ch,
  spdt_out_if.source out_ch
);

  localparam int KEY_W = (ID_BITS < ID_W) ? ID_BITS : ID_W;
  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);

  // Control state
  spdt_state_t      state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] scan_idx_r, scan_idx_nxt;
  logic             rd_vld_r, rd_vld_nxt;
  logic             out_valid_r, out_valid_nxt;

  // Working payload
  req_type_t        req_type_r, req_type_nxt;
  logic [KEY_W-1:0] key_a_r, key_a_nxt;
  logic [KEY_W-1:0] key_b_r, key_b_nxt;
  degree_t          deg_in_r, deg_in_nxt;
  logic [IDX_W-1:0] rd_idx_r, rd_idx_nxt;
  logic [IDX_W-1:0] hit_idx_r, hit_idx_nxt;
  logic             found_r, found_nxt;
  degree_t          old_deg_r, old_deg_nxt;

  // Result register
  logic             pair_found_r, pair_found_nxt;
  degree_t          degree_out_r, degree_out_nxt;
  logic             is_ally_r, is_ally_nxt;
  level_t           level_r, level_nxt;
  logic             dropped_r, dropped_nxt;

  // Memory ports
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic [KEY_W-1:0] rd_first, rd_second;
  degree_t          rd_degree;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;

  logic             hit;
  logic             full;

  spdt_store #(
    .DEPTH (ENTRIES),
    .KEY_W (KEY_W)
  ) u_store (
    .clk       (clk),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_first  (rd_first),
    .rd_second (rd_second),
    .rd_degree (rd_degree),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_first  (key_a_r),
    .wr_second (key_b_r),
    .wr_degree (deg_in_r)
  );

  // Shared pair comparator, either order
  assign hit  = ((rd_first == key_a_r) && (rd_second == key_b_r)) ||
                ((rd_first == key_b_r) && (rd_second == key_a_r));
  assign full = (count_r == CNT_W'(ENTRIES));

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    scan_idx_nxt   = scan_idx_r;
    rd_vld_nxt     = 1'b0;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    req_type_nxt   = req_type_r;
    key_a_nxt      = key_a_r;
    key_b_nxt      = key_b_r;
    deg_in_nxt     = deg_in_r;
    rd_idx_nxt     = rd_idx_r;
    hit_idx_nxt    = hit_idx_r;
    found_nxt      = found_r;
    old_deg_nxt    = old_deg_r;
    pair_found_nxt = pair_found_r;
    degree_out_nxt = degree_out_r;
    is_ally_nxt    = is_ally_r;
    level_nxt      = level_r;
    dropped_nxt    = dropped_r;
    rd_en          = 1'b0;
    rd_addr        = scan_idx_r[IDX_W-1:0];
    wr_en          = 1'b0;
    wr_addr        = hit_idx_r;
    in_ch.ready    = (state_r == ST_IDLE);

    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          req_type_nxt = in_ch.req_type;
          key_a_nxt    = in_ch.first_id[KEY_W-1:0];
          key_b_nxt    = in_ch.second_id[KEY_W-1:0];
          deg_in_nxt   = in_ch.degree_in;
          scan_idx_nxt = '0;
          found_nxt    = 1'b0;
          state_nxt    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (rd_vld_r && hit) begin
          // first match wins; no further reads are issued
          found_nxt   = 1'b1;
          hit_idx_nxt = rd_idx_r;
          old_deg_nxt = rd_degree;
          state_nxt   = ST_FINISH;
        end else if (scan_idx_r < count_r) begin
          rd_en        = 1'b1;
          rd_vld_nxt   = 1'b1;
          rd_idx_nxt   = scan_idx_r[IDX_W-1:0];
          scan_idx_nxt = scan_idx_r + 1'b1;
        end else begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          pair_found_nxt = found_r;
          degree_out_nxt = found_r ? old_deg_r : '0;
          is_ally_nxt    = found_r && (old_deg_r != '0);
          level_nxt      = (found_r && (old_deg_r != '0)) ? LEVEL_ALLY : LEVEL_NONE;
          dropped_nxt    = 1'b0;
          if (req_type_r == REQ_UPDATE) begin
            if (found_r) begin
              wr_en   = 1'b1;
              wr_addr = hit_idx_r;
            end else if (!full) begin
              wr_en     = 1'b1;
              wr_addr   = count_r[IDX_W-1:0];
              count_nxt = count_r + 1'b1;
            end else begin
              dropped_nxt = 1'b1;
            end
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      scan_idx_r  <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      scan_idx_r  <= scan_idx_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    req_type_r   <= req_type_nxt;
    key_a_r      <= key_a_nxt;
    key_b_r      <= key_b_nxt;
    deg_in_r     <= deg_in_nxt;
    rd_idx_r     <= rd_idx_nxt;
    hit_idx_r    <= hit_idx_nxt;
    found_r      <= found_nxt;
    old_deg_r    <= old_deg_nxt;
    pair_found_r <= pair_found_nxt;
    degree_out_r <= degree_out_nxt;
    is_ally_r    <= is_ally_nxt;
    level_r      <= level_nxt;
    dropped_r    <= dropped_nxt;
  end

  // Result channel
  assign out_ch.valid          = out_valid_r;
  assign out_ch.pair_found     = pair_found_r;
  assign out_ch.degree_out     = degree_out_r;
  assign out_ch.is_ally        = is_ally_r;
  assign out_ch.friend_level   = level_r;
  assign out_ch.insert_dropped = dropped_r;

endmodule

@@ rtl/spdt_checker.sv @@
// ----------------------------------------------------------------------------
// spdt_checker
// Port-level checks for the symmetric pair degree table, bound to the top.
// ----------------------------------------------------------------------------
module spdt_checker import spdt_pkg::*; (
  input logic    clk,
  input logic    rst_n,
  input logic    in_valid,
  input logic    in_ready,
  input logic    out_valid,
  input logic    out_ready,
  input logic    pair_found,
  input degree_t degree_out,
  input logic    is_ally,
  input level_t  friend_level,
  input logic    insert_dropped
);

  // A pending result is held until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result transaction dropped while stalled");

  // Ally flag and level follow the reported degree
  a_ally: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (is_ally == (pair_found && (degree_out != '0))) &&
                  (friend_level == (is_ally ? LEVEL_ALLY : LEVEL_NONE)))
    else $error("ally flag or level inconsistent with degree");

  // A miss reports zero degree; a dropped insert was never a hit
  a_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (!pair_found || insert_dropped) |-> !pair_found && (degree_out == '0))
    else $error("miss or dropped insert with nonzero report");

  // The sequencer is busy right after taking a request
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while a search is running");

  // A result cannot appear the cycle after a request is accepted
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("result produced without a search");

endmodule

bind symmetric_pair_degree_table spdt_checker u_spdt_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .pair_found     (out_ch.pair_found),
  .degree_out     (out_ch.degree_out),
  .is_ally        (out_ch.is_ally),
  .friend_level   (out_ch.friend_level),
  .insert_dropped (out_ch.insert_dropped)
);
